@@ hdl/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// i2a_pkg
// Word types, character codes and cell control for the integer to ASCII
// converter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_LOW_A = 7'h61;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  localparam logic CMD_DEC = 1'b0;
  localparam logic CMD_HEX = 1'b1;

  typedef struct packed {
    logic signed [31:0] value;
    logic               command;
  } req_word_t;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic       last;
  } rsp_word_t;

  typedef struct packed {
    logic clear;
    logic conv;
    logic shift;
    logic hex;
  } cell_ctl_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_LOW_A + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

@@ hdl/i2a_cell.sv @@
// ----------------------------------------------------------------------------
// i2a_cell
// One digit cell: shift-and-add-3 step in decimal, plain bit shift in hex,
// digit-wise shift toward the top of the chain while characters go out.
// ----------------------------------------------------------------------------
module i2a_cell (
  input  logic              clk,
  input  i2a_pkg::cell_ctl_t ctl,
  input  logic              cin,
  input  logic [3:0]        din,
  output logic              cout,
  output logic [3:0]        dout
);
  import i2a_pkg::*;

  logic [3:0] digit;
  logic [3:0] adj;

  always_comb begin
    if (!ctl.hex && digit >= 4'd5) begin
      adj = digit + 4'd3;
    end else begin
      adj = digit;
    end
  end

  assign cout = adj[3];
  assign dout = digit;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= 4'd0;
    end else if (ctl.conv) begin
      digit <= {adj[2:0], cin};
    end else if (ctl.shift) begin
      digit <= din;
    end
  end

endmodule

@@ hdl/integer_to_ascii_converter_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_converter_top
// Signed integer to ASCII decimal or lowercase hexadecimal string.
// ----------------------------------------------------------------------------
// req carries one word: value and command (0 decimal with sign, 1 hex).
// rsp returns the characters of that number, most significant first, with
// last set on the final one. Both channels use valid/stall.
// A request is taken only while the converter is idle. The magnitude is
// shifted MSB first into a chain of digit cells, one bit per cycle.
// Leading zero digits are then shifted out at one per cycle until the top
// digit is found or only one digit is left; then an optional '-' and each
// digit character are sent in turn, waiting while rsp stalls.
// Skipped and emitted digits together cover all the cells, 11 cells for
// DATA_WIDTH = 32.
// The result sits in an output register; a stalled rsp holds its word and
// the chain waits until the register frees up.
// Reset returns the controller to idle and drops rsp_valid; cell contents
// are cleared when each request is taken.
// ----------------------------------------------------------------------------
module integer_to_ascii_converter_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  i2a_pkg::req_word_t req,
  input  logic               req_valid,
  output logic               req_stall,
  output i2a_pkg::rsp_word_t rsp,
  output logic               rsp_valid,
  input  logic               rsp_stall
);
  import i2a_pkg::*;

  localparam int DEC_DIGITS = (DATA_WIDTH * 3 + 9) / 10 + 1;
  localparam int HEX_DIGITS = (DATA_WIDTH + 3) / 4;
  localparam int NDIG = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int XW   = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam int BW   = $clog2(DATA_WIDTH);
  localparam int DW   = $clog2(NDIG + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t                  state;
  logic [DATA_WIDTH-1:0]   mag;
  logic [BW-1:0]           bitcnt;
  logic [DW-1:0]           dcnt;
  logic                    hex;
  logic                    neg;

  logic [XW-1:0]           vx;
  logic [DATA_WIDTH-1:0]   v;
  logic                    req_neg;
  logic                    req_acc;
  logic                    can_load;
  logic                    rsp_load;
  logic [3:0]              top_digit;
  cell_ctl_t               ctl;

  logic [NDIG-1:0]         carry;
  logic [3:0]              digits [NDIG];

  assign vx       = XW'(req.value);
  assign v        = vx[DATA_WIDTH-1:0];
  assign req_neg  = (req.command == CMD_DEC) && v[DATA_WIDTH-1];
  assign req_stall = (state != S_IDLE);
  assign req_acc  = req_valid && !req_stall;
  assign can_load = !rsp_valid || !rsp_stall;
  assign rsp_load = ((state == S_SIGN) || (state == S_EMIT)) && can_load;
  assign top_digit = digits[NDIG-1];

  always_comb begin
    ctl.clear = req_acc;
    ctl.conv  = (state == S_CONV);
    ctl.shift = ((state == S_SKIP) && top_digit == 4'd0 && dcnt != DW'(1)) ||
                ((state == S_EMIT) && can_load);
    ctl.hex   = hex;
  end

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    i2a_cell u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .cin  ((i == 0) ? mag[DATA_WIDTH-1] : carry[(i == 0) ? 0 : i - 1]),
      .din  ((i == 0) ? 4'd0 : digits[(i == 0) ? 0 : i - 1]),
      .cout (carry[i]),
      .dout (digits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (bitcnt == BW'(DATA_WIDTH - 1)) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (!(top_digit == 4'd0 && dcnt != DW'(1))) begin
            state <= neg ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (can_load) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (can_load && dcnt == DW'(1)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      mag    <= req_neg ? (DATA_WIDTH'(0) - v) : v;
      hex    <= (req.command == CMD_HEX);
      neg    <= req_neg;
      bitcnt <= '0;
    end
    if (state == S_CONV) begin
      mag    <= {mag[DATA_WIDTH-2:0], 1'b0};
      bitcnt <= bitcnt + BW'(1);
      dcnt   <= DW'(NDIG);
    end
    if (ctl.shift) begin
      dcnt <= dcnt - DW'(1);
    end
    if (state == S_SIGN && can_load) begin
      rsp.ascii_char <= CHAR_MINUS;
      rsp.last       <= 1'b0;
    end
    if (state == S_EMIT && can_load) begin
      rsp.ascii_char <= digit_char(top_digit);
      rsp.last       <= (dcnt == DW'(1));
    end
  end

endmodule

@@ dv/tb_integer_to_ascii_converter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_converter_top
// Self-checking bench for the integer to ASCII converter.
// ----------------------------------------------------------------------------
// Numbers are sent on req. Each taken word is turned into its expected
// characters by a local formatter: signed decimal, or unsigned lowercase hex.
// Every rsp word is checked against the oldest expected character. Stimulus
// covers directed corner values, then random values under three sender and
// receiver idle mixes. A long rsp hold makes the converter back up and stall
// req.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_converter_top;
  import i2a_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 80;
  localparam int BACKLOG_HOLD   = 400;

  logic      clk;
  logic      rst = 1'b1;
  req_word_t req = '0;
  logic      req_valid = 1'b0;
  logic      req_stall;
  rsp_word_t rsp;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;

  rsp_word_t pending_chars[$];
  int        mismatch_count = 0;
  int        numbers_taken = 0;
  int        hex_taken = 0;
  int        chars_checked = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_len = 0;
  int        hold_seq = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  integer_to_ascii_converter_top #(
    .DATA_WIDTH(32)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp      (rsp),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // expected character string for one number, most significant first
  function automatic void predict_chars(input req_word_t w);
    logic [31:0] mag;
    logic [31:0] radix;
    logic [31:0] d;
    logic        neg;
    logic [6:0]  rev[$];
    rsp_word_t   c;
    neg   = (w.command == CMD_DEC) && w.value[31];
    mag   = neg ? (~w.value + 32'd1) : w.value;
    radix = (w.command == CMD_HEX) ? 32'd16 : 32'd10;
    if (mag == 32'd0) begin
      rev.push_back(CHAR_ZERO);
    end else begin
      while (mag != 32'd0) begin
        d = mag % radix;
        rev.push_back((d < 32'd10) ? CHAR_ZERO + 7'(d) : CHAR_LOW_A + 7'(d - 32'd10));
        mag = mag / radix;
      end
    end
    if (neg) begin
      rev.push_back(CHAR_MINUS);
    end
    for (int k = rev.size() - 1; k >= 0; k--) begin
      c.ascii_char = rev[k];
      c.last       = (k == 0);
      pending_chars.push_back(c);
    end
  endfunction

  // rsp check first, then record the req word taken at this edge
  always @(posedge clk) begin
    rsp_word_t exp_c;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        chars_checked++;
        if (pending_chars.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word char=%h last=%b", $time, rsp.ascii_char, rsp.last);
        end else begin
          exp_c = pending_chars.pop_front();
          if (rsp.ascii_char !== exp_c.ascii_char) begin
            mismatch_count++;
            $display("%0t: ascii_char expected %h actual %h", $time, exp_c.ascii_char,
                     rsp.ascii_char);
          end
          if (rsp.last !== exp_c.last) begin
            mismatch_count++;
            $display("%0t: last expected %b actual %b", $time, exp_c.last, rsp.last);
          end
        end
      end
      if (req_valid && !req_stall) begin
        numbers_taken++;
        if (req.command == CMD_HEX) begin
          hex_taken++;
        end
        predict_chars(req);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall plus an optional long hold
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_number(input logic signed [31:0] value, input logic command);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req.value   <= value;
    req.command <= command;
    req_valid   <= 1'b1;
    @(posedge clk);
    while (req_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic signed [31:0] random_value();
    logic [31:0] v;
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 99);
      2: begin
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        v = p + $urandom_range(0, 2) - 32'd1;
      end
      3: v = (32'd1 << (4 * $urandom_range(0, 7))) - $urandom_range(0, 1);
      4: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 2) == 0) begin
      v = ~v + 32'd1;
    end
    return v;
  endfunction

  task automatic test_corner_values();
    send_number(0, CMD_DEC);
    send_number(0, CMD_HEX);
    send_number(1, CMD_DEC);
    send_number(-1, CMD_DEC);
    send_number(-1, CMD_HEX);
    send_number(9, CMD_DEC);
    send_number(10, CMD_DEC);
    send_number(-10, CMD_DEC);
    send_number(100, CMD_DEC);
    send_number(32'sh7fff_ffff, CMD_DEC);
    send_number(32'sh7fff_ffff, CMD_HEX);
    send_number(32'sh8000_0000, CMD_DEC);
    send_number(32'sh8000_0000, CMD_HEX);
    send_number(15, CMD_HEX);
    send_number(16, CMD_HEX);
    send_number(10, CMD_HEX);
    send_number(255, CMD_HEX);
    send_number(32'shdead_beef, CMD_HEX);
    send_number(32'shdead_beef, CMD_DEC);
    send_number(32'sh1000_0000, CMD_HEX);
    send_number(1234567890, CMD_DEC);
    send_number(1000000000, CMD_DEC);
    send_number(-999999999, CMD_DEC);
    send_number(32'sh0abc_def0, CMD_HEX);
    wait_drained();
  endtask

  task automatic test_random_numbers(input int count);
    for (int i = 0; i < count; i++) begin
      send_number(random_value(), $urandom_range(0, 1) ? CMD_HEX : CMD_DEC);
    end
    wait_drained();
  endtask

  task automatic test_output_backlog();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len      = BACKLOG_HOLD;
    hold_seq++;
    for (int i = 0; i < 16; i++) begin
      send_number(random_value(), $urandom_range(0, 1) ? CMD_HEX : CMD_DEC);
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 22;
    recv_idle_pct = 62;
    test_corner_values();
    test_random_numbers(110);

    send_idle_pct = 62;
    recv_idle_pct = 22;
    test_random_numbers(110);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_numbers(110);

    test_output_backlog();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Converted %0d numbers (%0d hex, %0d decimal), %0d characters checked,",
             numbers_taken, hex_taken, numbers_taken - hex_taken, chars_checked);
    $display("under three idle mixes and one long output hold.");
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/i2a_pkg.sv
hdl/i2a_cell.sv
hdl/integer_to_ascii_converter_top.sv
dv/tb_integer_to_ascii_converter_top.sv
